[hw/rtl/tksd_pkg.sv]
// ----------------------------------------------------------------------------
// tksd_pkg
// Types, codes and lookup functions of the terminal key sequence decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

  // input commands
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [1:0] CMD_ENDED   = 2'd2;

  // key event codes
  localparam logic [4:0] EV_UNKNOWN  = 5'd0;
  localparam logic [4:0] EV_CHAR     = 5'd1;
  localparam logic [4:0] EV_TIMEOUT  = 5'd2;
  localparam logic [4:0] EV_ENDED    = 5'd3;
  localparam logic [4:0] EV_UP       = 5'd4;
  localparam logic [4:0] EV_DOWN     = 5'd5;
  localparam logic [4:0] EV_LEFT     = 5'd6;
  localparam logic [4:0] EV_RIGHT    = 5'd7;
  localparam logic [4:0] EV_HOME     = 5'd8;
  localparam logic [4:0] EV_END      = 5'd9;
  localparam logic [4:0] EV_PGUP     = 5'd10;
  localparam logic [4:0] EV_PGDN     = 5'd11;
  localparam logic [4:0] EV_INS      = 5'd12;
  localparam logic [4:0] EV_DEL      = 5'd13;
  localparam logic [4:0] EV_F10      = 5'd14;
  localparam logic [4:0] EV_CTRLHOME = 5'd15;
  localparam logic [4:0] EV_CTRLEND  = 5'd16;

  // bytes of interest
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_PREFIX = 8'd224;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_UPPERO = 8'h4F;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_FIVE   = 8'h35;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPERA = 8'h41;
  localparam logic [7:0] CH_UPPERB = 8'h42;
  localparam logic [7:0] CH_UPPERC = 8'h43;
  localparam logic [7:0] CH_UPPERD = 8'h44;
  localparam logic [7:0] CH_UPPERF = 8'h46;
  localparam logic [7:0] CH_UPPERH = 8'h48;

  // PC scan codes
  localparam logic [7:0] SC_UP       = 8'd72;
  localparam logic [7:0] SC_DOWN     = 8'd80;
  localparam logic [7:0] SC_LEFT     = 8'd75;
  localparam logic [7:0] SC_RIGHT    = 8'd77;
  localparam logic [7:0] SC_HOME     = 8'd71;
  localparam logic [7:0] SC_END      = 8'd79;
  localparam logic [7:0] SC_PGUP     = 8'd73;
  localparam logic [7:0] SC_PGDN     = 8'd81;
  localparam logic [7:0] SC_INS      = 8'd82;
  localparam logic [7:0] SC_DEL      = 8'd83;
  localparam logic [7:0] SC_F10      = 8'd68;
  localparam logic [7:0] SC_CTRLHOME = 8'd119;
  localparam logic [7:0] SC_CTRLEND  = 8'd117;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC   = 3'd1,
    PH_INTRO = 3'd2,
    PH_DIGIT = 3'd3,
    PH_F10   = 3'd4,
    PH_SEMI  = 3'd5,
    PH_MOD   = 3'd6,
    PH_SCAN  = 3'd7
  } phase_t;

  typedef struct packed {
    logic [4:0] ev;
    logic [7:0] ch;
  } result_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } q_entry_t;

  function automatic logic [4:0] letter_key(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      CH_UPPERA: k = EV_UP;
      CH_UPPERB: k = EV_DOWN;
      CH_UPPERC: k = EV_RIGHT;
      CH_UPPERD: k = EV_LEFT;
      CH_UPPERH: k = EV_HOME;
      CH_UPPERF: k = EV_END;
      default:   k = EV_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] tilde_key(input logic [3:0] d);
    logic [4:0] k;
    case (d)
      4'd1:    k = EV_HOME;
      4'd2:    k = EV_INS;
      4'd3:    k = EV_DEL;
      4'd4:    k = EV_END;
      4'd5:    k = EV_PGUP;
      4'd6:    k = EV_PGDN;
      4'd7:    k = EV_HOME;
      4'd8:    k = EV_END;
      default: k = EV_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] scan_key(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      SC_UP:       k = EV_UP;
      SC_DOWN:     k = EV_DOWN;
      SC_LEFT:     k = EV_LEFT;
      SC_RIGHT:    k = EV_RIGHT;
      SC_HOME:     k = EV_HOME;
      SC_END:      k = EV_END;
      SC_PGUP:     k = EV_PGUP;
      SC_PGDN:     k = EV_PGDN;
      SC_INS:      k = EV_INS;
      SC_DEL:      k = EV_DEL;
      SC_F10:      k = EV_F10;
      SC_CTRLHOME: k = EV_CTRLHOME;
      SC_CTRLEND:  k = EV_CTRLEND;
      default:     k = EV_UNKNOWN;
    endcase
    return k;
  endfunction

  // end of a sequence: the key, or a plain ESC when nothing matched
  function automatic result_t finish_res(input logic [4:0] k);
    result_t r;
    if (k == EV_UNKNOWN) begin
      r.ev = EV_CHAR;
      r.ch = CH_ESC;
    end else begin
      r.ev = k;
      r.ch = 8'd0;
    end
    return r;
  endfunction

endpackage

[hw/rtl/terminal_key_sequence_decoder.sv]
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder
// Decodes keyboard bytes, timeouts and end of input into key events.
// ----------------------------------------------------------------------------
// The decoder takes one input transfer per clock and decodes it in the same
// cycle against its sequence state; the zero, one or two key events it causes
// go into a four-entry result queue, one event leaving per clock. Input is
// held off (in_ready low) while more than two events wait in the queue, so
// the input side runs at one transfer per cycle as long as the output side
// takes events as fast as they come; an ESC followed by a plain byte makes
// two events, which leave the queue one after the other. Writing cfg_write_data via
// cfg_write_en selects ANSI (0) or PC scan-code (1) decoding and returns the
// decoder to idle; write it only while no transfer is in flight.
module terminal_key_sequence_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [7:0] byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] event_res,
  output logic [7:0] char_value,
  output logic       last
);

  logic                scan_code_mode;
  tksd_pkg::phase_t    phase, phase_next;
  logic                intro_is_o, intro_is_o_next;
  logic [3:0]          held_digit, held_digit_next;
  logic                modifier_is_five, modifier_is_five_next;

  logic [1:0]          n_res;
  tksd_pkg::result_t   res0, res1;

  tksd_pkg::q_entry_t  queue [tksd_pkg::QDEPTH];
  logic [tksd_pkg::QAW-1:0] wr_ptr, rd_ptr, wr_ptr_1;
  logic [tksd_pkg::QCW-1:0] count;

  logic in_xfer, out_xfer, is_byte, is_digit;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign is_byte  = (command == tksd_pkg::CMD_BYTE);
  assign is_digit = (byte_value >= tksd_pkg::CH_ZERO) && (byte_value <= tksd_pkg::CH_NINE);

  // next state of the sequence decoder
  always_comb begin
    phase_next            = phase;
    intro_is_o_next       = intro_is_o;
    held_digit_next       = held_digit;
    modifier_is_five_next = modifier_is_five;
    if (is_byte || command == tksd_pkg::CMD_TIMEOUT || command == tksd_pkg::CMD_ENDED) begin
      if (scan_code_mode) begin
        if (!(phase == tksd_pkg::PH_SCAN && command == tksd_pkg::CMD_TIMEOUT)) begin
          phase_next            = tksd_pkg::PH_IDLE;
          intro_is_o_next       = 1'b0;
          held_digit_next       = 4'd0;
          modifier_is_five_next = 1'b0;
          if (phase != tksd_pkg::PH_SCAN && is_byte &&
              (byte_value == tksd_pkg::CH_NUL || byte_value == tksd_pkg::CH_PREFIX)) begin
            phase_next = tksd_pkg::PH_SCAN;
          end
        end
      end else begin
        // clear by default; sequence steps below override
        phase_next            = tksd_pkg::PH_IDLE;
        intro_is_o_next       = 1'b0;
        held_digit_next       = 4'd0;
        modifier_is_five_next = 1'b0;
        if (phase == tksd_pkg::PH_IDLE || phase == tksd_pkg::PH_SCAN) begin
          if (is_byte && byte_value == tksd_pkg::CH_ESC) begin
            phase_next = tksd_pkg::PH_ESC;
          end
        end else if (is_byte) begin
          case (phase)
            tksd_pkg::PH_ESC: begin
              if (byte_value == tksd_pkg::CH_LBRACK || byte_value == tksd_pkg::CH_UPPERO) begin
                phase_next      = tksd_pkg::PH_INTRO;
                intro_is_o_next = (byte_value == tksd_pkg::CH_UPPERO);
              end
            end
            tksd_pkg::PH_INTRO: begin
              if (!intro_is_o && is_digit) begin
                phase_next      = tksd_pkg::PH_DIGIT;
                held_digit_next = byte_value[3:0];
              end
            end
            tksd_pkg::PH_DIGIT: begin
              if (held_digit == 4'd2 && byte_value == tksd_pkg::CH_ONE) begin
                phase_next      = tksd_pkg::PH_F10;
                held_digit_next = held_digit;
              end else if (held_digit == 4'd1 && byte_value == tksd_pkg::CH_SEMI) begin
                phase_next      = tksd_pkg::PH_SEMI;
                held_digit_next = held_digit;
              end
            end
            tksd_pkg::PH_SEMI: begin
              phase_next            = tksd_pkg::PH_MOD;
              held_digit_next       = held_digit;
              modifier_is_five_next = (byte_value == tksd_pkg::CH_FIVE);
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // key events caused by the current input
  always_comb begin
    n_res = 2'd0;
    res0  = '0;
    res1  = '0;
    if (is_byte || command == tksd_pkg::CMD_TIMEOUT || command == tksd_pkg::CMD_ENDED) begin
      if (scan_code_mode) begin
        if (phase == tksd_pkg::PH_SCAN) begin
          if (command != tksd_pkg::CMD_TIMEOUT) begin
            n_res  = 2'd1;
            res0.ev = is_byte ? tksd_pkg::scan_key(byte_value) : tksd_pkg::EV_UNKNOWN;
          end
        end else if (command == tksd_pkg::CMD_TIMEOUT) begin
          n_res   = 2'd1;
          res0.ev = tksd_pkg::EV_TIMEOUT;
        end else if (command == tksd_pkg::CMD_ENDED) begin
          n_res   = 2'd1;
          res0.ev = tksd_pkg::EV_ENDED;
        end else if (byte_value != tksd_pkg::CH_NUL && byte_value != tksd_pkg::CH_PREFIX) begin
          n_res   = 2'd1;
          res0.ev = tksd_pkg::EV_CHAR;
          res0.ch = byte_value;
        end
      end else if (phase == tksd_pkg::PH_IDLE || phase == tksd_pkg::PH_SCAN) begin
        if (command == tksd_pkg::CMD_TIMEOUT) begin
          n_res   = 2'd1;
          res0.ev = tksd_pkg::EV_TIMEOUT;
        end else if (command == tksd_pkg::CMD_ENDED) begin
          n_res   = 2'd1;
          res0.ev = tksd_pkg::EV_ENDED;
        end else if (byte_value != tksd_pkg::CH_ESC) begin
          n_res   = 2'd1;
          res0.ev = tksd_pkg::EV_CHAR;
          res0.ch = byte_value;
        end
      end else if (!is_byte) begin
        n_res = 2'd1;
        res0  = tksd_pkg::finish_res(tksd_pkg::EV_UNKNOWN);
      end else begin
        case (phase)
          tksd_pkg::PH_ESC: begin
            if (byte_value != tksd_pkg::CH_LBRACK && byte_value != tksd_pkg::CH_UPPERO) begin
              // ESC then an ordinary byte: both come out as characters
              n_res = 2'd2;
              res0  = tksd_pkg::finish_res(tksd_pkg::EV_UNKNOWN);
              res1.ev = tksd_pkg::EV_CHAR;
              res1.ch = byte_value;
            end
          end
          tksd_pkg::PH_INTRO: begin
            if (intro_is_o || !is_digit) begin
              n_res = 2'd1;
              res0  = tksd_pkg::finish_res(tksd_pkg::letter_key(byte_value));
            end
          end
          tksd_pkg::PH_DIGIT: begin
            if (byte_value == tksd_pkg::CH_TILDE) begin
              n_res = 2'd1;
              res0  = tksd_pkg::finish_res(tksd_pkg::tilde_key(held_digit));
            end else if (!(held_digit == 4'd2 && byte_value == tksd_pkg::CH_ONE) &&
                         !(held_digit == 4'd1 && byte_value == tksd_pkg::CH_SEMI)) begin
              n_res = 2'd1;
              res0  = tksd_pkg::finish_res(tksd_pkg::EV_UNKNOWN);
            end
          end
          tksd_pkg::PH_F10: begin
            n_res = 2'd1;
            res0  = tksd_pkg::finish_res(byte_value == tksd_pkg::CH_TILDE ?
                                         tksd_pkg::EV_F10 : tksd_pkg::EV_UNKNOWN);
          end
          tksd_pkg::PH_MOD: begin
            n_res = 2'd1;
            if (modifier_is_five && byte_value == tksd_pkg::CH_UPPERH) begin
              res0 = tksd_pkg::finish_res(tksd_pkg::EV_CTRLHOME);
            end else if (modifier_is_five && byte_value == tksd_pkg::CH_UPPERF) begin
              res0 = tksd_pkg::finish_res(tksd_pkg::EV_CTRLEND);
            end else begin
              res0 = tksd_pkg::finish_res(tksd_pkg::EV_UNKNOWN);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // decoder state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_code_mode   <= 1'b0;
      phase            <= tksd_pkg::PH_IDLE;
      intro_is_o       <= 1'b0;
      held_digit       <= 4'd0;
      modifier_is_five <= 1'b0;
    end else if (cfg_write_en) begin
      scan_code_mode   <= cfg_write_data;
      phase            <= tksd_pkg::PH_IDLE;
      intro_is_o       <= 1'b0;
      held_digit       <= 4'd0;
      modifier_is_five <= 1'b0;
    end else if (in_xfer) begin
      phase            <= phase_next;
      intro_is_o       <= intro_is_o_next;
      held_digit       <= held_digit_next;
      modifier_is_five <= modifier_is_five_next;
    end
  end

  // result queue
  assign wr_ptr_1 = wr_ptr + tksd_pkg::QAW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr <= wr_ptr + tksd_pkg::QAW'(n_res);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + tksd_pkg::QAW'(1);
      end
      count <= count + tksd_pkg::QCW'(in_xfer ? n_res : 2'd0)
                     - tksd_pkg::QCW'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && n_res != 2'd0) begin
      queue[wr_ptr] <= '{res: res0, last: (n_res == 2'd1)};
    end
    if (in_xfer && n_res == 2'd2) begin
      queue[wr_ptr_1] <= '{res: res1, last: 1'b1};
    end
  end

  assign in_ready   = (count <= tksd_pkg::QCW'(tksd_pkg::QDEPTH - 2));
  assign out_valid  = (count != '0);
  assign event_res  = queue[rd_ptr].res.ev;
  assign char_value = queue[rd_ptr].res.ch;
  assign last       = queue[rd_ptr].last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tksd_pkg::QCW'(tksd_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_write_en |=> (phase == tksd_pkg::PH_IDLE && held_digit == 4'd0))
    else $error("configuration write did not clear the decoder");

  a_scan_phases: assert property (@(posedge clk) disable iff (rst)
    scan_code_mode |-> (phase == tksd_pkg::PH_IDLE || phase == tksd_pkg::PH_SCAN))
    else $error("ANSI phase reached in scan-code mode");

  a_f10_digit: assert property (@(posedge clk) disable iff (rst)
    (phase == tksd_pkg::PH_F10) |-> (held_digit == 4'd2))
    else $error("F10 phase without digit 2");

  a_semi_digit: assert property (@(posedge clk) disable iff (rst)
    (phase == tksd_pkg::PH_SEMI || phase == tksd_pkg::PH_MOD) |-> (held_digit == 4'd1))
    else $error("modifier phase without digit 1");

endmodule
